// ----- rtl/core/multi_slot_oneshot_periodic_timer_top_defines.svh -----
// Assertion macros shared by the checker of the timer bank.
// Each expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MULTI_SLOT_ONESHOT_PERIODIC_TIMER_TOP_DEFINES_SVH
`define MULTI_SLOT_ONESHOT_PERIODIC_TIMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSOT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold from the cycle after the antecedent.
`define MSOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- rtl/core/msot_pkg.sv -----
package msot_pkg;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int VALUE_W    = 32;
    localparam int MASK_W     = 16;
    localparam int TICK_OUT_W = 32;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_TICK_BITS = 32;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic capture;
        logic tick_inc;
        logic idx_clr;
        logic scan_rd;
        logic eval;
        logic exec;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_tick;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/msot_if.sv -----
interface msot_in_if;
    import msot_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic                periodic;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, command, slot, periodic, value, input ready);
    modport sink (input valid, command, slot, periodic, value, output ready);
endinterface

interface msot_out_if;
    import msot_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MASK_W-1:0]     fired_mask;
    logic [TICK_OUT_W-1:0] tick_now;
    logic                  armed;

    modport source (output valid, fired_mask, tick_now, armed, input ready);
    modport sink (input valid, fired_mask, tick_now, armed, output ready);
endinterface

// ----- rtl/core/msot_ram.sv -----
module msot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/msot_ctrl.sv -----
module msot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msot_pkg::t_dp_stat i_stat,
    output msot_pkg::t_ctl_cmd o_cmd
);
    import msot_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_evp;
    logic       n_evp;

    always_comb begin
        n_state    = r_state;
        n_evp      = r_evp;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_evp      = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.tick_inc = i_stat.in_tick;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = i_stat.in_tick ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.eval    = r_evp;
                n_evp         = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.eval = r_evp;
                n_evp      = 1'b0;
                n_state    = S_DONE;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_evp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_evp   <= n_evp;
        end
    end
endmodule

// ----- rtl/core/msot_dp.sv -----
module msot_dp #(
    parameter int NUM_SLOTS = msot_pkg::DEF_NUM_SLOTS,
    parameter int TICK_BITS = msot_pkg::DEF_TICK_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [msot_pkg::CMD_W-1:0]      i_command,
    input  logic [msot_pkg::SLOT_W-1:0]     i_slot,
    input  logic                            i_periodic,
    input  logic [msot_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [msot_pkg::MASK_W-1:0]     o_fired_mask,
    output logic [msot_pkg::TICK_OUT_W-1:0] o_tick_now,
    output logic                            o_armed,
    input  msot_pkg::t_ctl_cmd              i_cmd,
    output msot_pkg::t_dp_stat              o_stat
);
    import msot_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [TICK_BITS-1:0]  r_tick;
    logic [CMD_W-1:0]      r_cmd;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_per;
    logic [TICK_BITS-1:0]  r_val;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [NUM_SLOTS-1:0]  r_armed;
    logic [NUM_SLOTS-1:0]  n_armed;
    logic [NUM_SLOTS-1:0]  r_periodic;
    logic [NUM_SLOTS-1:0]  n_periodic;
    logic [NUM_SLOTS-1:0]  r_fired;
    logic                  r_arm_res;
    logic                  r_out_valid;
    logic [MASK_W-1:0]     r_out_mask;
    logic [TICK_OUT_W-1:0] r_out_tick;
    logic                  r_out_armed;

    logic [TICK_BITS-1:0]  w_exp_rd;
    logic [TICK_BITS-1:0]  w_per_rd;
    logic                  w_hit;
    logic [TICK_BITS-1:0]  w_reload;
    logic                  w_keep;
    logic                  w_slot_ok;
    logic [IDX_W-1:0]      w_slot_idx;
    logic                  w_start;
    logic                  w_stop;
    logic [TICK_BITS-1:0]  w_start_exp;
    logic                  w_start_arm;
    logic                  w_exp_we;
    logic [IDX_W-1:0]      w_exp_waddr;
    logic [TICK_BITS-1:0]  w_exp_wdata;
    logic                  w_per_we;
    logic [MASK_W-1:0]     w_mask;

    // Evaluation of the slot whose memory words were read in the previous cycle.
    assign w_hit    = r_armed[r_rd_idx] && (w_exp_rd <= r_tick);
    assign w_reload = TICK_BITS'(w_per_rd + r_tick);
    assign w_keep   = r_periodic[r_rd_idx] && (w_reload > r_tick);

    assign w_slot_ok   = (32'(r_slot) < 32'(NUM_SLOTS));
    assign w_slot_idx  = IDX_W'(r_slot);
    assign w_start     = i_cmd.exec && (r_cmd == CMD_START) && w_slot_ok;
    assign w_stop      = i_cmd.exec && (r_cmd == CMD_STOP) && w_slot_ok;
    assign w_start_exp = r_per ? TICK_BITS'(r_val + r_tick) : r_val;
    assign w_start_arm = (w_start_exp > r_tick);

    assign w_exp_we    = (i_cmd.eval && w_hit && r_periodic[r_rd_idx]) || w_start;
    assign w_exp_waddr = i_cmd.eval ? r_rd_idx : w_slot_idx;
    assign w_exp_wdata = i_cmd.eval ? w_reload : w_start_exp;
    assign w_per_we    = w_start && r_per;

    msot_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (w_exp_we),
        .i_waddr (w_exp_waddr),
        .i_wdata (w_exp_wdata),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_idx),
        .o_rdata (w_exp_rd)
    );

    msot_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (w_per_we),
        .i_waddr (w_slot_idx),
        .i_wdata (r_val),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_idx),
        .o_rdata (w_per_rd)
    );

    always_comb begin
        n_armed    = r_armed;
        n_periodic = r_periodic;
        if (i_cmd.eval && w_hit) begin
            n_armed[r_rd_idx] = w_keep;
        end
        if (w_start) begin
            n_armed[w_slot_idx]    = w_start_arm;
            n_periodic[w_slot_idx] = r_per;
        end
        if (w_stop) begin
            n_armed[w_slot_idx] = 1'b0;
        end
    end

    // Only the first sixteen slots are reported.
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < NUM_SLOTS) begin : g_live
            assign w_mask[b] = r_fired[b];
        end else begin : g_none
            assign w_mask[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_armed     <= '0;
            r_periodic  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + 1'b1;
            end
            r_armed    <= n_armed;
            r_periodic <= n_periodic;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_command;
            r_slot    <= i_slot;
            r_per     <= i_periodic;
            r_val     <= TICK_BITS'(i_value);
            r_fired   <= '0;
            r_arm_res <= 1'b0;
        end else begin
            if (i_cmd.eval && w_hit) begin
                r_fired[r_rd_idx] <= 1'b1;
            end
            if (w_start) begin
                r_arm_res <= w_start_arm;
            end
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.load_out) begin
            r_out_mask  <= w_mask;
            r_out_tick  <= TICK_OUT_W'(r_tick);
            r_out_armed <= r_arm_res;
        end
    end

    assign o_stat.in_tick  = (i_command == CMD_TICK);
    assign o_stat.idx_last = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_fired_mask = r_out_mask;
    assign o_tick_now   = r_out_tick;
    assign o_armed      = r_out_armed;
endmodule

// ----- rtl/core/multi_slot_oneshot_periodic_timer_top.sv -----
// Bank of NUM_SLOTS one-shot or periodic timers driven by a TICK_BITS-bit tick counter.
// Each item is a tick, a start or a stop command and yields exactly one result item.
// A tick scans the slots one per cycle through the read port of the expiry and period
// memories, drains the evaluation of the last slot read and then loads its result into
// the output register; start, stop and unknown commands pass an execute state before
// their result is loaded. One item is worked on at a time, and the next item is accepted
// only once the result of the last one has been loaded. A finished result waits in an
// output register while the next item is already being accepted and processed; a second
// result that is ready while the first still waits holds the bank until the output
// register is taken.
module multi_slot_oneshot_periodic_timer_top #(
    parameter int NUM_SLOTS = msot_pkg::DEF_NUM_SLOTS,
    parameter int TICK_BITS = msot_pkg::DEF_TICK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msot_in_if.sink     i_in,
    msot_out_if.source  o_out
);
    import msot_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    msot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    msot_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_command    (i_in.command),
        .i_slot       (i_in.slot),
        .i_periodic   (i_in.periodic),
        .i_value      (i_in.value),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_fired_mask (o_out.fired_mask),
        .o_tick_now   (o_out.tick_now),
        .o_armed      (o_out.armed),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

    assign i_in.ready = w_in_ready;
endmodule

// ----- rtl/core/msot_chk.sv -----
`include "multi_slot_oneshot_periodic_timer_top_defines.svh"

module msot_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [msot_pkg::CMD_W-1:0]      i_in_command,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [msot_pkg::MASK_W-1:0]     i_out_fired_mask,
    input logic [msot_pkg::TICK_OUT_W-1:0] i_out_tick_now,
    input logic                            i_out_armed
);
    import msot_pkg::*;

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    // A stalled result keeps its place and its contents.
    `MSOT_ASSERT_NEXT(a_out_hold, w_out_stall, i_out_valid)
    `MSOT_ASSERT_NEXT(a_out_stable, w_out_stall, $stable(i_out_fired_mask) && $stable(i_out_tick_now) && $stable(i_out_armed))
    // The bank works on one item at a time, and a tick passes through the scan state before the bank is ready again.
    `MSOT_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !i_in_ready)
    `MSOT_ASSERT_NEXT(a_tick_scans, w_in_acc && (i_in_command == CMD_TICK), ##1 !i_in_ready)
endmodule

bind multi_slot_oneshot_periodic_timer_top msot_chk u_msot_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_command     (i_in.command),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_fired_mask (o_out.fired_mask),
    .i_out_tick_now   (o_out.tick_now),
    .i_out_armed      (o_out.armed)
);
